>>> rtl/bfds_pkg.sv
// Shared types, constants and the ordering function of the depth sorter.
`timescale 1ns / 1ps

package bfds_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int COORD_W   = 24;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * COORD_W + 1;
	localparam int DIST_W    = 50;
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_APPEND = 2'd0;
	localparam kind_t KIND_ITEM   = 2'd1;
	localparam kind_t KIND_EMPTY  = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_CAMERA_X = 2'd0;
	localparam cfg_idx_t REG_CAMERA_Y = 2'd1;
	localparam cfg_idx_t REG_CAMERA_Z = 2'd2;

	typedef struct packed {
		logic [DIST_W-1:0] dist_sq;
		logic [2:0]        dim;
		logic [15:0]       chunk_x;
		logic [15:0]       chunk_z;
		logic [7:0]        slot;
		logic [15:0]       handle;
		logic              xf;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_SUM,
		ST_INS,
		ST_DRAIN
	} state_t;

	// true when a must leave strictly ahead of b
	function automatic logic goes_before(entry_t a, entry_t b);
		if (a.dist_sq != b.dist_sq) return a.dist_sq > b.dist_sq;
		if (a.dim != b.dim) return a.dim < b.dim;
		if (a.chunk_x != b.chunk_x) return $signed(a.chunk_x) < $signed(b.chunk_x);
		if (a.chunk_z != b.chunk_z) return $signed(a.chunk_z) < $signed(b.chunk_z);
		return a.slot < b.slot;
	endfunction

endpackage

>>> rtl/bfds_in_if.sv
// Request channel: append or sort requests with item fields.
`timescale 1ns / 1ps

interface bfds_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [23:0] center_x;
	logic signed [23:0] center_y;
	logic signed [23:0] center_z;
	logic        [2:0]  dimension_code;
	logic signed [15:0] chunk_x;
	logic signed [15:0] chunk_z;
	logic        [7:0]  slot_index;
	logic        [15:0] item_handle;
	logic               transformed_flag;

	modport source (
		output valid, req_type, center_x, center_y, center_z, dimension_code,
		output chunk_x, chunk_z, slot_index, item_handle, transformed_flag,
		input  ready
	);
	modport sink (
		input  valid, req_type, center_x, center_y, center_z, dimension_code,
		input  chunk_x, chunk_z, slot_index, item_handle, transformed_flag,
		output ready
	);
endinterface

>>> rtl/bfds_out_if.sv
// Result channel: append answers and sorted items.
`timescale 1ns / 1ps

interface bfds_out_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  result_kind;
	logic               accepted;
	logic        [15:0] out_handle;
	logic               out_transformed;
	logic        [49:0] out_distance_sq;
	logic        [2:0]  out_dimension;
	logic signed [15:0] out_chunk_x;
	logic signed [15:0] out_chunk_z;
	logic        [7:0]  out_slot;
	logic               last;

	modport source (
		output valid, result_kind, accepted, out_handle, out_transformed,
		output out_distance_sq, out_dimension, out_chunk_x, out_chunk_z, out_slot, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, accepted, out_handle, out_transformed,
		input  out_distance_sq, out_dimension, out_chunk_x, out_chunk_z, out_slot, last,
		output ready
	);
endinterface

>>> rtl/bfds_dist.sv
// Squared distance pipeline: difference, square, sum over three stages.
`timescale 1ns / 1ps

module bfds_dist (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic signed [bfds_pkg::COORD_W-1:0]  center_x,
	input  logic signed [bfds_pkg::COORD_W-1:0]  center_y,
	input  logic signed [bfds_pkg::COORD_W-1:0]  center_z,
	input  logic signed [bfds_pkg::COORD_W-1:0]  camera_x,
	input  logic signed [bfds_pkg::COORD_W-1:0]  camera_y,
	input  logic signed [bfds_pkg::COORD_W-1:0]  camera_z,
	output logic        [bfds_pkg::DIST_W-1:0]   dist_sq
);
	logic signed [bfds_pkg::DIFF_W-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [2*bfds_pkg::DIFF_W-1:0] px, py, pz;
	logic        [bfds_pkg::SQ_W-1:0]     sx_s2, sy_s2, sz_s2;
	logic        [bfds_pkg::DIST_W-1:0]   dist_s3;

	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	always_ff @(posedge clk) begin
		if (load) begin
			dx_s1 <= bfds_pkg::DIFF_W'(center_x) - bfds_pkg::DIFF_W'(camera_x);
			dy_s1 <= bfds_pkg::DIFF_W'(center_y) - bfds_pkg::DIFF_W'(camera_y);
			dz_s1 <= bfds_pkg::DIFF_W'(center_z) - bfds_pkg::DIFF_W'(camera_z);
		end
		sx_s2   <= px[bfds_pkg::SQ_W-1:0];
		sy_s2   <= py[bfds_pkg::SQ_W-1:0];
		sz_s2   <= pz[bfds_pkg::SQ_W-1:0];
		dist_s3 <= bfds_pkg::DIST_W'(sx_s2) + bfds_pkg::DIST_W'(sy_s2)
			+ bfds_pkg::DIST_W'(sz_s2);
	end

	assign dist_sq = dist_s3;
endmodule

>>> rtl/bfds_cell.sv
// One sorting cell: holds an entry, inserts the new entry or its neighbour's, or shifts forward.
`timescale 1ns / 1ps

module bfds_cell (
	input  logic                   clk,
	input  bfds_pkg::cell_ctrl_t   ctrl,
	input  logic                   occupied,
	input  bfds_pkg::entry_t       new_entry,
	input  logic                   prev_ins,
	input  bfds_pkg::entry_t       prev_entry,
	input  bfds_pkg::entry_t       next_entry,
	output logic                   ins,
	output bfds_pkg::entry_t       entry
);
	bfds_pkg::entry_t entry_q;

	assign ins   = !occupied || bfds_pkg::goes_before(new_entry, entry_q);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			entry_q <= next_entry;
		end else if (ctrl.insert && ins) begin
			entry_q <= prev_ins ? prev_entry : new_entry;
		end
	end
endmodule

>>> rtl/back_to_front_depth_sorter.sv
// Top level: camera registers, distance pipeline, sorting chain and result register.
//
//  channel | dir | transfer when        | payload
//  req     | in  | req.valid&&req.ready | request type, centre, keys, handle, flag
//  rsp     | out | rsp.valid&&rsp.ready | kind, accepted, entry fields, last
//  cfg     | in  | cfg_we               | camera x/y/z by cfg_index
//
// An append passes three distance stages (difference, square, sum), then one
// insertion into the chain of cells. A sort emits one stored item per cycle
// from the head of the chain while the result register is free, or one empty
// answer for an empty chain. A stalled result register holds the sequencer;
// one request is taken while a result waits. Reset empties the chain at once.
`timescale 1ns / 1ps

module back_to_front_depth_sorter (
	input  logic                             clk,
	input  logic                             arst_n,
	bfds_in_if.sink                          req,
	bfds_out_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [bfds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfds_pkg::COORD_W-1:0]     cfg_data
);
	localparam int N = bfds_pkg::MAX_ITEMS;

	bfds_pkg::state_t                state_q, state_d;
	logic [bfds_pkg::CNT_W-1:0]      count_q;
	logic [bfds_pkg::COORD_W-1:0]    cam_x_q, cam_y_q, cam_z_q;
	bfds_pkg::entry_t                item_q, new_entry, head;
	logic [bfds_pkg::DIST_W-1:0]     dist_sq;
	bfds_pkg::cell_ctrl_t            ctrl;
	logic                            accept, slot_free, load_out, full;
	bfds_pkg::entry_t                entry_w [N];
	logic                            ins_w [N];

	bfds_pkg::kind_t                 kind_q, kind_d;
	logic                            acc_q, acc_d, last_q, last_d, out_valid_q;
	bfds_pkg::entry_t                out_q, out_d;

	assign req.ready = (state_q == bfds_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign full      = (count_q == bfds_pkg::CNT_W'(N));
	assign head      = entry_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bfds_pkg::REG_CAMERA_X: cam_x_q <= cfg_data;
				bfds_pkg::REG_CAMERA_Y: cam_y_q <= cfg_data;
				bfds_pkg::REG_CAMERA_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bfds_dist u_dist (
		.clk      (clk),
		.load     (accept),
		.center_x (req.center_x),
		.center_y (req.center_y),
		.center_z (req.center_z),
		.camera_x ($signed(cam_x_q)),
		.camera_y ($signed(cam_y_q)),
		.camera_z ($signed(cam_z_q)),
		.dist_sq  (dist_sq)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.dist_sq <= '0;
			item_q.dim     <= req.dimension_code;
			item_q.chunk_x <= req.chunk_x;
			item_q.chunk_z <= req.chunk_z;
			item_q.slot    <= req.slot_index;
			item_q.handle  <= req.item_handle;
			item_q.xf      <= req.transformed_flag;
		end
	end

	always_comb begin
		new_entry         = item_q;
		new_entry.dist_sq = dist_sq;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		bfds_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > bfds_pkg::CNT_W'(i)),
			.new_entry  (new_entry),
			.prev_ins   ((i == 0) ? 1'b0 : ins_w[(i == 0) ? 0 : i - 1]),
			.prev_entry (entry_w[(i == 0) ? 0 : i - 1]),
			.next_entry ((i == N - 1) ? bfds_pkg::entry_t'('0) : entry_w[(i == N - 1) ? i : i + 1]),
			.ins        (ins_w[i]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.insert = 1'b0;
		ctrl.shift  = 1'b0;
		load_out    = 1'b0;
		kind_d      = bfds_pkg::KIND_APPEND;
		acc_d       = 1'b0;
		last_d      = 1'b1;
		out_d       = '0;
		case (state_q)
			bfds_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = req.req_type ? bfds_pkg::ST_DRAIN : bfds_pkg::ST_SQ;
				end
			end
			bfds_pkg::ST_SQ:  state_d = bfds_pkg::ST_SUM;
			bfds_pkg::ST_SUM: state_d = bfds_pkg::ST_INS;
			bfds_pkg::ST_INS: begin
				if (slot_free) begin
					load_out    = 1'b1;
					ctrl.insert = !full;
					acc_d       = !full;
					state_d     = bfds_pkg::ST_IDLE;
				end
			end
			bfds_pkg::ST_DRAIN: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (count_q == '0) begin
						kind_d  = bfds_pkg::KIND_EMPTY;
						state_d = bfds_pkg::ST_IDLE;
					end else begin
						kind_d     = bfds_pkg::KIND_ITEM;
						out_d      = head;
						last_d     = (count_q == bfds_pkg::CNT_W'(1));
						ctrl.shift = 1'b1;
						if (last_d) state_d = bfds_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = bfds_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.insert) begin
				count_q <= count_q + bfds_pkg::CNT_W'(1);
			end else if (ctrl.shift) begin
				count_q <= count_q - bfds_pkg::CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q <= kind_d;
			acc_q  <= acc_d;
			last_q <= last_d;
			out_q  <= out_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.result_kind     = kind_q;
	assign rsp.accepted        = acc_q;
	assign rsp.out_handle      = out_q.handle;
	assign rsp.out_transformed = out_q.xf;
	assign rsp.out_distance_sq = out_q.dist_sq;
	assign rsp.out_dimension   = out_q.dim;
	assign rsp.out_chunk_x     = out_q.chunk_x;
	assign rsp.out_chunk_z     = out_q.chunk_z;
	assign rsp.out_slot        = out_q.slot;
	assign rsp.last            = last_q;
endmodule

>>> rtl/bfds_chk.sv
// Port-level checks on the result stream of the depth sorter, with its bind.
`timescale 1ns / 1ps

module bfds_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic        rsp_accepted,
	input logic [49:0] rsp_dist,
	input logic        rsp_last
);
	logic        in_sort_q;
	logic [49:0] prev_dist_q;
	logic        xfer;

	assign xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sort_q <= 1'b0;
		end else if (xfer) begin
			in_sort_q <= (rsp_kind == bfds_pkg::KIND_ITEM) && !rsp_last;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) prev_dist_q <= rsp_dist;
	end

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == bfds_pkg::KIND_APPEND || rsp_kind == bfds_pkg::KIND_EMPTY)
		|-> rsp_last)
		else $error("single-result answer without last");

	a_item_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != bfds_pkg::KIND_APPEND |-> !rsp_accepted)
		else $error("accepted set outside an append answer");

	a_back_to_front: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && in_sort_q |-> rsp_kind == bfds_pkg::KIND_ITEM && rsp_dist <= prev_dist_q)
		else $error("sorted stream out of order or interrupted");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_dist))
		else $error("stalled result dropped or changed");
endmodule

bind back_to_front_depth_sorter bfds_chk u_bfds_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_kind     (rsp.result_kind),
	.rsp_accepted (rsp.accepted),
	.rsp_dist     (rsp.out_distance_sq),
	.rsp_last     (rsp.last)
);

>>> sim/depth_order_checker.sv
// Request codes and the checker that predicts and compares the depth sorter's results.
`timescale 1ns / 1ps

package sorter_req_pkg;
	typedef enum logic {
		REQ_APPEND = 1'b0,
		REQ_SORT   = 1'b1
	} req_kind_t;
endpackage

module depth_order_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	bfds_in_if                             req,
	bfds_out_if                            rsp,
	input  logic                           cfg_we,
	input  logic [bfds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfds_pkg::COORD_W-1:0]   cfg_data,
	output int                             failures,
	output int                             outstanding
);
	import bfds_pkg::*;
	import sorter_req_pkg::*;

	typedef struct {
		logic [DIST_W-1:0] dist_sq;
		logic [2:0]        dim;
		logic signed [15:0] chunk_x;
		logic signed [15:0] chunk_z;
		logic [7:0]        slot;
		logic [15:0]       handle;
		logic              xf;
	} held_item_t;

	typedef struct {
		kind_t             kind;
		logic              accepted;
		logic [15:0]       handle;
		logic              xf;
		logic [DIST_W-1:0] dist_sq;
		logic [2:0]        dim;
		logic [15:0]       chunk_x;
		logic [15:0]       chunk_z;
		logic [7:0]        slot;
		logic              last;
	} sorter_result_t;

	logic signed [COORD_W-1:0] cam_x = '0;
	logic signed [COORD_W-1:0] cam_y = '0;
	logic signed [COORD_W-1:0] cam_z = '0;
	held_item_t held [MAX_ITEMS];
	int held_count = 0;
	sorter_result_t expected_q [$];

	initial failures = 0;
	initial outstanding = 0;

	function automatic logic [DIST_W-1:0] axis_square(logic signed [COORD_W-1:0] p,
			logic signed [COORD_W-1:0] c);
		logic signed [COORD_W:0] d;
		logic [COORD_W:0] mag;
		d = p - c;
		mag = d[COORD_W] ? -d : d;
		return DIST_W'(mag) * DIST_W'(mag);
	endfunction

	function automatic bit further_back(held_item_t a, held_item_t b);
		if (a.dist_sq != b.dist_sq) return a.dist_sq > b.dist_sq;
		if (a.dim != b.dim) return a.dim < b.dim;
		if (a.chunk_x != b.chunk_x) return a.chunk_x < b.chunk_x;
		if (a.chunk_z != b.chunk_z) return a.chunk_z < b.chunk_z;
		return a.slot < b.slot;
	endfunction

	task automatic compare(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		held_item_t fresh;
		sorter_result_t want;
		int order [MAX_ITEMS];
		int i;
		int j;
		if (!arst_n) begin
			expected_q.delete();
			held_count = 0;
			cam_x = '0;
			cam_y = '0;
			cam_z = '0;
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_q.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, expected none actual kind %0h handle %0h",
						$time, rsp.result_kind, rsp.out_handle);
				end else begin
					want = expected_q.pop_front();
					compare("result_kind", want.kind, rsp.result_kind);
					compare("accepted", want.accepted, rsp.accepted);
					compare("out_handle", want.handle, rsp.out_handle);
					compare("out_transformed", want.xf, rsp.out_transformed);
					compare("out_distance_sq", want.dist_sq, rsp.out_distance_sq);
					compare("out_dimension", want.dim, rsp.out_dimension);
					compare("out_chunk_x", want.chunk_x, $unsigned(rsp.out_chunk_x));
					compare("out_chunk_z", want.chunk_z, $unsigned(rsp.out_chunk_z));
					compare("out_slot", want.slot, rsp.out_slot);
					compare("last", want.last, rsp.last);
				end
			end

			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				want = '{default: '0};
				want.last = 1'b1;
				if (req.req_type == REQ_APPEND) begin
					want.kind = KIND_APPEND;
					if (held_count < MAX_ITEMS) begin
						fresh.dist_sq = axis_square(req.center_x, cam_x)
							+ axis_square(req.center_y, cam_y)
							+ axis_square(req.center_z, cam_z);
						fresh.dim = req.dimension_code;
						fresh.chunk_x = req.chunk_x;
						fresh.chunk_z = req.chunk_z;
						fresh.slot = req.slot_index;
						fresh.handle = req.item_handle;
						fresh.xf = req.transformed_flag;
						held[held_count] = fresh;
						held_count++;
						want.accepted = 1'b1;
					end
					expected_q.push_back(want);
				end else if (held_count == 0) begin
					want.kind = KIND_EMPTY;
					expected_q.push_back(want);
				end else begin
					// stable insertion sort keeps full ties in arrival order
					for (i = 0; i < held_count; i++) begin
						j = i;
						while (j > 0 && further_back(held[i], held[order[j-1]])) begin
							order[j] = order[j-1];
							j--;
						end
						order[j] = i;
					end
					for (i = 0; i < held_count; i++) begin
						fresh = held[order[i]];
						want.kind = KIND_ITEM;
						want.handle = fresh.handle;
						want.xf = fresh.xf;
						want.dist_sq = fresh.dist_sq;
						want.dim = fresh.dim;
						want.chunk_x = fresh.chunk_x;
						want.chunk_z = fresh.chunk_z;
						want.slot = fresh.slot;
						want.last = (i == held_count - 1);
						expected_q.push_back(want);
					end
					held_count = 0;
				end
			end

			if (cfg_we === 1'b1) begin
				case (cfg_index)
					REG_CAMERA_X: cam_x = cfg_data;
					REG_CAMERA_Y: cam_y = cfg_data;
					REG_CAMERA_Z: cam_z = cfg_data;
					default: ;
				endcase
			end
		end
		outstanding <= expected_q.size();
	end

endmodule

>>> sim/testbench.sv
// Top of the depth sorter testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
	import bfds_pkg::*;
	import sorter_req_pkg::*;

	typedef struct {
		req_kind_t                 kind;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [2:0]                dim;
		logic signed [15:0]        chunk_x;
		logic signed [15:0]        chunk_z;
		logic [7:0]                slot;
		logic [15:0]               handle;
		logic                      xf;
	} request_t;

	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [COORD_W-1:0] cfg_data;
	int failures;
	int outstanding;

	bit send_idle;
	bit recv_idle;
	logic [COORD_W-1:0] cam_x = '0;
	logic [COORD_W-1:0] cam_y = '0;
	logic [COORD_W-1:0] cam_z = '0;
	int sent = 0;
	int sorts = 0;
	int camera_sets = 0;

	bfds_in_if  req_ch ();
	bfds_out_if rsp_ch ();

	back_to_front_depth_sorter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	depth_order_checker order_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic request_t append_req(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [COORD_W-1:0] cz, logic [2:0] dim, logic [15:0] chunk_x,
			logic [15:0] chunk_z, logic [7:0] slot, logic [15:0] handle, logic xf);
		request_t r;
		r.kind = REQ_APPEND;
		r.cx = cx;
		r.cy = cy;
		r.cz = cz;
		r.dim = dim;
		r.chunk_x = chunk_x;
		r.chunk_z = chunk_z;
		r.slot = slot;
		r.handle = handle;
		r.xf = xf;
		return r;
	endfunction

	// clustered items sit within one step of the camera on each axis to force distance and key ties
	function automatic request_t random_append(bit clustered);
		request_t r;
		int off_x;
		int off_y;
		int off_z;
		r = append_req(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
			1'($urandom));
		if (clustered) begin
			off_x = $urandom_range(0, 2);
			off_y = $urandom_range(0, 2);
			off_z = $urandom_range(0, 2);
			r.cx = cam_x + COORD_W'(256 * (off_x - 1));
			r.cy = cam_y + COORD_W'(256 * (off_y - 1));
			r.cz = cam_z + COORD_W'(256 * (off_z - 1));
			r.dim = 3'($urandom_range(0, 1));
			r.chunk_x = 16'($urandom_range(0, 2)) - 16'd1;
			r.chunk_z = 16'($urandom_range(0, 2)) - 16'd1;
			r.slot = 8'($urandom_range(0, 2));
		end
		return r;
	endfunction

	function automatic request_t sort_req();
		request_t r;
		r = random_append(1'b0);
		r.kind = REQ_SORT;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return COORD_MIN;
			1: return COORD_MAX;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	task automatic send(request_t r);
		int gap;
		gap = send_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.center_x <= r.cx;
		req_ch.center_y <= r.cy;
		req_ch.center_z <= r.cz;
		req_ch.dimension_code <= r.dim;
		req_ch.chunk_x <= r.chunk_x;
		req_ch.chunk_z <= r.chunk_z;
		req_ch.slot_index <= r.slot;
		req_ch.item_handle <= r.handle;
		req_ch.transformed_flag <= r.xf;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent++;
		if (r.kind == REQ_SORT)
			sorts++;
	endtask

	// hold off until every result owed has arrived and the block has gone quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cameras(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		cfg_we <= 1'b1;
		cfg_index <= REG_CAMERA_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= REG_CAMERA_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_index <= REG_CAMERA_Z;
		cfg_data <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		cam_x = x;
		cam_y = y;
		cam_z = z;
		camera_sets++;
	endtask

	initial begin : drain
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_idle ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	initial begin : stimulus
		int phase;
		int n;
		bit clustered;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CAMERA_X;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_APPEND;
		req_ch.center_x <= '0;
		req_ch.center_y <= '0;
		req_ch.center_z <= '0;
		req_ch.dimension_code <= '0;
		req_ch.chunk_x <= '0;
		req_ch.chunk_z <= '0;
		req_ch.slot_index <= '0;
		req_ch.item_handle <= '0;
		req_ch.transformed_flag <= 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(sort_req());
		send(append_req(COORD_MAX, COORD_MAX, COORD_MAX, 3'd7, 16'h8000, 16'h7fff, 8'hff,
			16'hffff, 1'b1));
		send(append_req(COORD_MIN, COORD_MIN, COORD_MIN, 3'd0, 16'h7fff, 16'h8000, 8'h00,
			16'h0000, 1'b0));
		send(append_req('0, '0, '0, 3'd3, 16'd0, 16'd0, 8'd9, 16'h1234, 1'b0));
		send(append_req(24'd256, '0, '0, 3'd1, 16'd5, 16'd0, 8'd3, 16'h0a01, 1'b1));
		send(append_req('0, 24'd256, '0, 3'd1, 16'd5, 16'd0, 8'd3, 16'h0a02, 1'b0));
		send(append_req('0, '0, -24'sd256, 3'd0, 16'd5, 16'd0, 8'd3, 16'h0a03, 1'b0));
		send(append_req(-24'sd256, '0, '0, 3'd1, -16'sd5, 16'd0, 8'd3, 16'h0a04, 1'b1));
		send(append_req(24'd256, '0, '0, 3'd1, 16'd5, -16'sd1, 8'd3, 16'h0a05, 1'b0));
		send(append_req(24'd256, '0, '0, 3'd1, 16'd5, 16'd0, 8'd2, 16'h0a06, 1'b1));
		send(append_req(24'd256, '0, '0, 3'd1, 16'd5, 16'd0, 8'd3, 16'h0a07, 1'b0));
		send(sort_req());

		settle();
		write_cameras(COORD_MIN, COORD_MIN, COORD_MIN);
		send(append_req(COORD_MAX, COORD_MAX, COORD_MAX, 3'd2, 16'd1, 16'd1, 8'd1,
			16'hbeef, 1'b1));
		send(append_req(COORD_MIN, COORD_MIN, COORD_MIN, 3'd2, 16'd1, 16'd1, 8'd1,
			16'h0001, 1'b0));
		send(append_req('0, '0, '0, 3'd4, 16'd0, 16'd0, 8'd0, 16'h5555, 1'b1));
		settle();
		write_cameras(COORD_MAX, COORD_MAX, COORD_MAX);
		send(append_req(COORD_MIN, COORD_MIN, COORD_MIN, 3'd5, 16'hffff, 16'h0001, 8'h80,
			16'haaaa, 1'b0));
		send(sort_req());
		send(sort_req());

		phase = 0;
		while (sent < 114) begin
			phase++;
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			clustered = $urandom_range(0, 1);
			if (phase % 3 == 0) begin
				settle();
				write_cameras(pick_coord(), pick_coord(), pick_coord());
			end
			n = (phase == 2) ? MAX_ITEMS + 3 : $urandom_range(0, 10);
			repeat (n) send(random_append(clustered));
			send(sort_req());
			if ($urandom_range(0, 4) == 0)
				send(sort_req());
		end

		settle();
		$display("Summary: %0d requests (%0d sorts) under %0d camera settings,",
			sent, sorts, camera_sets + 1);
		$display("         including ties, coordinate extremes and a store overfilled past %0d.",
			MAX_ITEMS);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
